@@ design/obht_pkg.sv @@
// Shared types, field widths and codes of the order book hash table.
`timescale 1ns / 1ps
`default_nettype none

package obht_pkg;

  localparam int ID_W        = 31;
  localparam int QTY_W       = 31;
  localparam int PRICE_W     = 32;
  localparam int BUCKETS_DEF = 128;
  localparam int WAYS_DEF    = 4;

  typedef enum logic [1:0] {
    MODE_ADD     = 2'd0,
    MODE_CANCEL  = 2'd1,
    MODE_REDUCE  = 2'd2,
    MODE_REPLACE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_DUP       = 3'd3,
    ST_CLAMP     = 3'd4
  } status_e;

  typedef struct packed {
    mode_e                mode;
    logic [ID_W-1:0]      oid;
    logic                 side;
    logic [QTY_W-1:0]     quantity;
    logic [PRICE_W-1:0]   price;
  } in_t;

  typedef struct packed {
    status_e              status;
    logic [ID_W-1:0]      result_id;
    logic                 result_side;
    logic [QTY_W-1:0]     result_quantity;
    logic [PRICE_W-1:0]   result_price;
  } out_t;

  typedef struct packed {
    logic                 vld;
    logic [ID_W-1:0]      id;
    logic                 side;
    logic [QTY_W-1:0]     qty;
    logic [PRICE_W-1:0]   price;
  } entry_t;

endpackage

`default_nettype wire

@@ design/obht_row_ram.sv @@
// Bucket row memory: one row of all ways per bucket, registered read.
`timescale 1ns / 1ps
`default_nettype none

module obht_row_ram #(
  parameter int BUCKETS = obht_pkg::BUCKETS_DEF,
  parameter int WAYS    = obht_pkg::WAYS_DEF,
  localparam int AW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  wire                              clk_i,
  input  wire                              we_i,
  input  wire [AW-1:0]                     waddr_i,
  input  wire obht_pkg::entry_t [WAYS-1:0] wdata_i,
  input  wire                              re_i,
  input  wire [AW-1:0]                     raddr_i,
  output obht_pkg::entry_t [WAYS-1:0]      rdata_o
);

  obht_pkg::entry_t [WAYS-1:0] mem_q [BUCKETS];
  obht_pkg::entry_t [WAYS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/obht_bucket_index.sv @@
// Bucket index unit: order id modulo the bucket count, by mask or reciprocal multiply.
`timescale 1ns / 1ps
`default_nettype none

module obht_bucket_index #(
  parameter int BUCKETS = obht_pkg::BUCKETS_DEF,
  localparam int AW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire [obht_pkg::ID_W-1:0]     id_i,
  output logic                         done_o,
  output logic [AW-1:0]                idx_o
);

  localparam bit POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

  if (POW2) begin : g_mask
    logic [AW-1:0] idx_q;
    logic          done_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        idx_q  <= '0;
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
        if (start_i) begin
          idx_q <= (BUCKETS > 1) ? id_i[AW-1:0] : '0;
        end
      end
    end

    assign done_o = done_q;
    assign idx_o  = idx_q;
  end else begin : g_recip
    localparam int SH  = obht_pkg::ID_W + AW;
    localparam int PW  = obht_pkg::ID_W + 32;
    localparam int RW  = obht_pkg::ID_W + 2;
    localparam int AW1 = AW + 1;
    localparam logic [63:0] RECIP   = (64'd1 << SH) / 64'(BUCKETS);
    localparam logic [31:0] RECIP_C = RECIP[31:0];
    localparam logic [AW:0] MOD_C   = AW1'(BUCKETS);

    logic [obht_pkg::ID_W-1:0] id_q;
    logic [PW-1:0]             prod_q;
    logic [AW:0]               rem_q;
    logic [AW-1:0]             idx_q;
    logic                      v1_q;
    logic                      v2_q;
    logic                      done_q;
    logic [PW-1:0]             prod;
    logic [RW-1:0]             qb;
    logic [RW-1:0]             rem;
    logic [AW:0]               rem_fix;

    assign prod    = PW'(id_i) * PW'(RECIP_C);
    assign qb      = RW'(prod_q[PW-1:SH]) * RW'(BUCKETS);
    assign rem     = RW'(id_q) - qb;
    assign rem_fix = (rem_q >= MOD_C) ? (rem_q - MOD_C) : rem_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        id_q   <= '0;
        prod_q <= '0;
        rem_q  <= '0;
        idx_q  <= '0;
        v1_q   <= 1'b0;
        v2_q   <= 1'b0;
        done_q <= 1'b0;
      end else begin
        v1_q   <= start_i;
        v2_q   <= v1_q;
        done_q <= v2_q;
        if (start_i) begin
          id_q   <= id_i;
          prod_q <= prod;
        end
        if (v1_q) begin
          rem_q <= rem[AW:0];
        end
        if (v2_q) begin
          idx_q <= rem_fix[AW-1:0];
        end
      end
    end

    assign done_o = done_q;
    assign idx_o  = idx_q;
  end

endmodule

`default_nettype wire

@@ design/obht_bucket_update.sv @@
// Bucket update: search the ways, apply the operation, build the result word.
`timescale 1ns / 1ps
`default_nettype none

module obht_bucket_update #(
  parameter int WAYS = obht_pkg::WAYS_DEF
) (
  input  wire obht_pkg::entry_t [WAYS-1:0] row_i,
  input  wire obht_pkg::in_t               req_i,
  output obht_pkg::entry_t [WAYS-1:0]      row_o,
  output logic                             we_o,
  output obht_pkg::out_t                   res_o
);

  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic          hit;
  logic [WW-1:0] hit_w;
  logic          free;
  logic [WW-1:0] free_w;

  always_comb begin
    hit   = 1'b0;
    hit_w = '0;
    free  = 1'b0;
    free_w = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_i[w].vld && (row_i[w].id == req_i.oid)) begin
        hit   = 1'b1;
        hit_w = WW'(w);
      end
      if (!row_i[w].vld) begin
        free   = 1'b1;
        free_w = WW'(w);
      end
    end
  end

  always_comb begin
    row_o = row_i;
    we_o  = 1'b0;
    res_o.status          = obht_pkg::ST_NOT_FOUND;
    res_o.result_id       = req_i.oid;
    res_o.result_side     = 1'b0;
    res_o.result_quantity = '0;
    res_o.result_price    = '0;
    case (req_i.mode)
      obht_pkg::MODE_ADD: begin
        if (hit) begin
          res_o.status          = obht_pkg::ST_DUP;
          res_o.result_side     = row_i[hit_w].side;
          res_o.result_quantity = row_i[hit_w].qty;
          res_o.result_price    = row_i[hit_w].price;
        end else if (free) begin
          row_o[free_w].vld   = 1'b1;
          row_o[free_w].id    = req_i.oid;
          row_o[free_w].side  = req_i.side;
          row_o[free_w].qty   = req_i.quantity;
          row_o[free_w].price = req_i.price;
          we_o                = 1'b1;
          res_o.status          = obht_pkg::ST_OK;
          res_o.result_side     = req_i.side;
          res_o.result_quantity = req_i.quantity;
          res_o.result_price    = req_i.price;
        end else begin
          res_o.status = obht_pkg::ST_FULL;
        end
      end
      obht_pkg::MODE_CANCEL: begin
        if (hit) begin
          row_o[hit_w].vld   = 1'b0;
          we_o               = 1'b1;
          res_o.status       = obht_pkg::ST_OK;
          res_o.result_side  = row_i[hit_w].side;
          res_o.result_price = row_i[hit_w].price;
        end
      end
      obht_pkg::MODE_REDUCE: begin
        if (hit) begin
          we_o         = 1'b1;
          res_o.status = obht_pkg::ST_OK;
          if (row_i[hit_w].qty >= req_i.quantity) begin
            row_o[hit_w].qty = row_i[hit_w].qty - req_i.quantity;
          end else begin
            row_o[hit_w].qty = '0;
            res_o.status     = obht_pkg::ST_CLAMP;
          end
          res_o.result_side     = row_i[hit_w].side;
          res_o.result_quantity = row_o[hit_w].qty;
          res_o.result_price    = row_i[hit_w].price;
        end
      end
      obht_pkg::MODE_REPLACE: begin
        if (hit) begin
          row_o[hit_w].qty      = req_i.quantity;
          row_o[hit_w].price    = req_i.price;
          we_o                  = 1'b1;
          res_o.status          = obht_pkg::ST_OK;
          res_o.result_side     = row_i[hit_w].side;
          res_o.result_quantity = req_i.quantity;
          res_o.result_price    = req_i.price;
        end
      end
      default: begin
        we_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/order_book_hash_table_top.sv @@
// Order book hash table: top level with control, clearing pass and result register.
//
// Input channel in_*: one word per order operation (add, cancel, reduce,
// replace). A word is taken at a clock edge where in_valid_i is high and
// in_stall_o is low. Output channel out_*: exactly one result word per
// input word, in order, taken where out_valid_o is high and out_stall_i low.
// Each item runs alone: bucket index, one row read of the bucket memory,
// then modify and write back of that row while the result is registered.
// With a BUCKETS that is not a power of two, the index unit works in
// registered steps (reciprocal multiply, back multiply and subtract, one
// correction). Index, row read and write back run in turn for each item,
// and a new word is taken only after the result of the last one has been
// registered.
// After reset the block sweeps all BUCKETS rows, one a cycle, to clear the
// valid bits; in_stall_o stays high until the sweep has ended.
// A stalled result holds in the output register; the next item is still
// taken and proceeds up to its write back, where it waits for the register.
`timescale 1ns / 1ps
`default_nettype none

module order_book_hash_table_top #(
  parameter int BUCKETS = obht_pkg::BUCKETS_DEF,
  parameter int WAYS    = obht_pkg::WAYS_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire obht_pkg::in_t  in_word_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output obht_pkg::out_t      out_word_o
);

  localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_HASH  = 2'd2;
  localparam logic [1:0] S_READ  = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [AW-1:0]                clr_q, clr_d;
  obht_pkg::in_t                req_q;
  logic                         out_valid_q, out_valid_d;
  obht_pkg::out_t               out_q;

  logic                         accept;
  logic                         out_free;
  logic                         idx_done;
  logic [AW-1:0]                idx;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  obht_pkg::entry_t [WAYS-1:0]  mem_wdata;
  logic                         mem_re;
  obht_pkg::entry_t [WAYS-1:0]  row_rd;
  obht_pkg::entry_t [WAYS-1:0]  row_new;
  logic                         upd_we;
  obht_pkg::out_t               upd_res;
  logic                         finish;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == S_READ) && out_free;

  obht_bucket_index #(
    .BUCKETS (BUCKETS)
  ) u_index (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .id_i    (in_word_i.oid),
    .done_o  (idx_done),
    .idx_o   (idx)
  );

  assign mem_re    = (state_q == S_HASH) && idx_done;
  assign mem_we    = (state_q == S_CLEAR) || (finish && upd_we);
  assign mem_waddr = (state_q == S_CLEAR) ? clr_q : idx;
  assign mem_wdata = (state_q == S_CLEAR) ? '0 : row_new;

  obht_row_ram #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (idx),
    .rdata_o (row_rd)
  );

  obht_bucket_update #(
    .WAYS (WAYS)
  ) u_update (
    .row_i (row_rd),
    .req_i (req_q),
    .row_o (row_new),
    .we_o  (upd_we),
    .res_o (upd_res)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        if (clr_q == AW'(BUCKETS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (idx_done) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_word_i;
    end
    if (finish) begin
      out_q <= upd_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_accept_to_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_HASH)
    else $error("accepted word did not start the index step");

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_READ))
    else $error("result word appeared without a row read");

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) && (clr_q == AW'(BUCKETS - 1)) |=> state_q == S_IDLE)
    else $error("clearing pass did not end");

  a_full_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == obht_pkg::ST_FULL)
      |-> (out_word_o.result_quantity == '0) && (out_word_o.result_price == '0))
    else $error("full bucket result carries entry fields");
`endif

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Testbench for the order book hash table: directed table, then random traffic vs. predictor.
`timescale 1ns / 1ps

module tb;
  import obht_pkg::*;

  localparam int NB = BUCKETS_DEF;
  localparam int NW = WAYS_DEF;
  localparam int NE = NB * NW;
  localparam logic [ID_W-1:0]    IDMAX = {ID_W{1'b1}};
  localparam logic [QTY_W-1:0]   QMAX  = {QTY_W{1'b1}};
  localparam logic [PRICE_W-1:0] PMAX  = {PRICE_W{1'b1}};
  localparam int RANDOM_WORDS = 1930;
  localparam int IDLE_LIMIT   = 1000;

  typedef struct {
    in_t  w;
    bit   typed;
    out_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid_r = 1'b0;
  in_t  in_word_r = '0;
  logic out_stall_r = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_word_o;

  entry_t book [NE];
  out_t   pending_results [$];
  row_t   rows [$];
  int     err_cnt = 0;
  int     burst_left = 1;
  int     stall_run = 0;
  int     idle_cnt = 0;

  order_book_hash_table_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid_r),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_r),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_r),
    .out_word_o  (out_word_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic in_t mk_word(mode_e m, logic [ID_W-1:0] id, logic sd,
                                  logic [QTY_W-1:0] q, logic [PRICE_W-1:0] p);
    in_t w;
    w.mode = m;
    w.oid = id;
    w.side = sd;
    w.quantity = q;
    w.price = p;
    return w;
  endfunction

  function automatic out_t mk_res(status_e st, logic [ID_W-1:0] id, logic sd,
                                  logic [QTY_W-1:0] q, logic [PRICE_W-1:0] p);
    out_t r;
    r.status = st;
    r.result_id = id;
    r.result_side = sd;
    r.result_quantity = q;
    r.result_price = p;
    return r;
  endfunction

  function automatic out_t book_apply(in_t w);
    out_t r;
    int base;
    int hit;
    int fr;
    r = '0;
    r.status = ST_OK;
    r.result_id = w.oid;
    base = int'(w.oid % NB) * NW;
    hit = -1;
    fr = -1;
    for (int k = 0; k < NW; k++) begin
      if (hit < 0 && book[base+k].vld && book[base+k].id == w.oid) hit = base + k;
      if (fr < 0 && !book[base+k].vld) fr = base + k;
    end
    if (w.mode == MODE_ADD) begin
      if (hit >= 0) begin
        r.status = ST_DUP;
        r.result_side = book[hit].side;
        r.result_quantity = book[hit].qty;
        r.result_price = book[hit].price;
      end else if (fr < 0) begin
        r.status = ST_FULL;
      end else begin
        book[fr].vld = 1'b1;
        book[fr].id = w.oid;
        book[fr].side = w.side;
        book[fr].qty = w.quantity;
        book[fr].price = w.price;
        r.result_side = w.side;
        r.result_quantity = w.quantity;
        r.result_price = w.price;
      end
    end else if (hit < 0) begin
      r.status = ST_NOT_FOUND;
    end else begin
      case (w.mode)
        MODE_CANCEL: begin
          book[hit].vld = 1'b0;
        end
        MODE_REDUCE: begin
          if (book[hit].qty >= w.quantity) begin
            book[hit].qty = book[hit].qty - w.quantity;
          end else begin
            book[hit].qty = '0;
            r.status = ST_CLAMP;
          end
        end
        default: begin
          book[hit].qty = w.quantity;
          book[hit].price = w.price;
        end
      endcase
      r.result_side = book[hit].side;
      r.result_quantity = (w.mode == MODE_CANCEL) ? '0 : book[hit].qty;
      r.result_price = book[hit].price;
    end
    return r;
  endfunction

  function automatic logic [ID_W-1:0] hot_id();
    logic [23:0] hi;
    logic [6:0]  bkt;
    bkt = 7'($urandom_range(0, 15));
    hi = $urandom_range(0, 1) ? 24'($urandom_range(0, 7)) : 24'($urandom);
    return {hi, bkt};
  endfunction

  function automatic logic [ID_W-1:0] live_id();
    int start;
    start = $urandom_range(0, NE - 1);
    for (int k = 0; k < NE; k++) begin
      if (book[(start + k) % NE].vld) return book[(start + k) % NE].id;
    end
    return hot_id();
  endfunction

  function automatic in_t pick_word();
    in_t w;
    int  r;
    int  m;
    m = $urandom_range(0, 9);
    if (m < 4) w.mode = MODE_ADD;
    else if (m < 6) w.mode = MODE_CANCEL;
    else if (m < 8) w.mode = MODE_REDUCE;
    else w.mode = MODE_REPLACE;
    w.side = 1'($urandom);
    w.quantity = QTY_W'($urandom);
    if ($urandom_range(0, 3) != 0) w.quantity = QTY_W'($urandom_range(0, 5000));
    w.price = $urandom;
    r = $urandom_range(0, 99);
    if (r < 15) w.oid = ID_W'($urandom);
    else if (w.mode != MODE_ADD && r < 85) w.oid = live_id();
    else if (w.mode == MODE_ADD && r < 25) w.oid = live_id();
    else w.oid = hot_id();
    return w;
  endfunction

  task automatic send_word(in_t w, bit typed, out_t want);
    out_t pred;
    in_word_r <= w;
    in_valid_r <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pred = book_apply(w);
    pending_results.push_back(typed ? want : pred);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid_r <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 25);
    end
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_n && out_valid_o === 1'b1 && !out_stall_r) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("tb: unexpected result %p", out_word_o);
      end else begin
        want = pending_results.pop_front();
        if (out_word_o.status !== want.status ||
            out_word_o.result_id !== want.result_id ||
            out_word_o.result_side !== want.result_side ||
            out_word_o.result_quantity !== want.result_quantity ||
            out_word_o.result_price !== want.result_price) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("tb: mismatch exp st=%0d id=%h sd=%b q=%h p=%h",
                     want.status, want.result_id, want.result_side,
                     want.result_quantity, want.result_price);
            $display("tb:          got st=%0d id=%h sd=%b q=%h p=%h",
                     out_word_o.status, out_word_o.result_id, out_word_o.result_side,
                     out_word_o.result_quantity, out_word_o.result_price);
          end
        end
      end
    end
    if (stall_run == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          out_stall_r <= 1'b1;
          stall_run = $urandom_range(1, 20);
        end
        1: begin
          out_stall_r <= 1'b0;
          stall_run = $urandom_range(50, 200);
        end
        default: begin
          out_stall_r <= 1'($urandom);
          stall_run = $urandom_range(1, 4);
        end
      endcase
    end else begin
      stall_run--;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_r && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_r)) begin
      idle_cnt = 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cnt++;
    end
  end

  initial begin
    for (int k = 0; k < NE; k++) book[k] = '0;

    rows.push_back('{mk_word(MODE_CANCEL, 31'd5, 1'b0, 31'd0, 32'd0), 1'b1,
                     mk_res(ST_NOT_FOUND, 31'd5, 1'b0, 31'd0, 32'd0)});
    rows.push_back('{mk_word(MODE_REDUCE, IDMAX, 1'b1, 31'd1, PMAX), 1'b1,
                     mk_res(ST_NOT_FOUND, IDMAX, 1'b0, 31'd0, 32'd0)});
    rows.push_back('{mk_word(MODE_REPLACE, 31'd0, 1'b0, 31'd9, 32'd9), 1'b1,
                     mk_res(ST_NOT_FOUND, 31'd0, 1'b0, 31'd0, 32'd0)});
    rows.push_back('{mk_word(MODE_ADD, 31'd0, 1'b0, 31'd0, 32'd0), 1'b1,
                     mk_res(ST_OK, 31'd0, 1'b0, 31'd0, 32'd0)});
    rows.push_back('{mk_word(MODE_ADD, IDMAX, 1'b1, QMAX, PMAX), 1'b1,
                     mk_res(ST_OK, IDMAX, 1'b1, QMAX, PMAX)});
    rows.push_back('{mk_word(MODE_ADD, 31'd0, 1'b1, 31'd5, 32'd5), 1'b1,
                     mk_res(ST_DUP, 31'd0, 1'b0, 31'd0, 32'd0)});
    rows.push_back('{mk_word(MODE_ADD, 31'd128, 1'b1, 31'd100, 32'd10000), 1'b1,
                     mk_res(ST_OK, 31'd128, 1'b1, 31'd100, 32'd10000)});
    rows.push_back('{mk_word(MODE_ADD, 31'd256, 1'b0, 31'd200, 32'd20000), 1'b1,
                     mk_res(ST_OK, 31'd256, 1'b0, 31'd200, 32'd20000)});
    rows.push_back('{mk_word(MODE_ADD, 31'd384, 1'b1, 31'd300, 32'd30000), 1'b1,
                     mk_res(ST_OK, 31'd384, 1'b1, 31'd300, 32'd30000)});
    rows.push_back('{mk_word(MODE_ADD, 31'd512, 1'b0, 31'd1, 32'd1), 1'b1,
                     mk_res(ST_FULL, 31'd512, 1'b0, 31'd0, 32'd0)});
    rows.push_back('{mk_word(MODE_ADD, 31'd128, 1'b0, 31'd7, 32'd7), 1'b1,
                     mk_res(ST_DUP, 31'd128, 1'b1, 31'd100, 32'd10000)});
    rows.push_back('{mk_word(MODE_REDUCE, IDMAX, 1'b0, 31'd1, 32'd0), 1'b1,
                     mk_res(ST_OK, IDMAX, 1'b1, QMAX - 31'd1, PMAX)});
    rows.push_back('{mk_word(MODE_REDUCE, IDMAX, 1'b0, QMAX, 32'd0), 1'b1,
                     mk_res(ST_CLAMP, IDMAX, 1'b1, 31'd0, PMAX)});
    rows.push_back('{mk_word(MODE_REDUCE, IDMAX, 1'b1, 31'd0, PMAX), 1'b1,
                     mk_res(ST_OK, IDMAX, 1'b1, 31'd0, PMAX)});
    rows.push_back('{mk_word(MODE_REPLACE, IDMAX, 1'b0, QMAX, 32'h1234_5678), 1'b1,
                     mk_res(ST_OK, IDMAX, 1'b1, QMAX, 32'h1234_5678)});
    rows.push_back('{mk_word(MODE_CANCEL, 31'd128, 1'b0, QMAX, PMAX), 1'b1,
                     mk_res(ST_OK, 31'd128, 1'b1, 31'd0, 32'd10000)});
    rows.push_back('{mk_word(MODE_REDUCE, 31'd128, 1'b0, 31'd1, 32'd0), 1'b1,
                     mk_res(ST_NOT_FOUND, 31'd128, 1'b0, 31'd0, 32'd0)});
    rows.push_back('{mk_word(MODE_ADD, 31'd512, 1'b1, 31'd50, 32'd55), 1'b1,
                     mk_res(ST_OK, 31'd512, 1'b1, 31'd50, 32'd55)});
    rows.push_back('{mk_word(MODE_REDUCE, 31'd256, 1'b1, 31'd200, 32'd0), 1'b1,
                     mk_res(ST_OK, 31'd256, 1'b0, 31'd0, 32'd20000)});
    rows.push_back('{mk_word(MODE_CANCEL, 31'd0, 1'b1, 31'd0, 32'd0), 1'b1,
                     mk_res(ST_OK, 31'd0, 1'b0, 31'd0, 32'd0)});
    rows.push_back('{mk_word(MODE_ADD, 31'd640, 1'b1, 31'h2AAA_AAAA, 32'h5555_5555), 1'b0,
                     '0});
    rows.push_back('{mk_word(MODE_REPLACE, 31'd384, 1'b0, 31'h5555_5555, 32'hAAAA_AAAA),
                     1'b0, '0});
    rows.push_back('{mk_word(MODE_REDUCE, 31'd512, 1'b0, 31'd20, 32'd0), 1'b0, '0});
    rows.push_back('{mk_word(MODE_CANCEL, IDMAX, 1'b0, 31'd0, 32'd0), 1'b0, '0});

    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);
    for (int n = 0; n < RANDOM_WORDS; n++) send_word(pick_word(), 1'b0, '0);
    if (in_valid_r) in_valid_r <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
